@@ hw/rtl/k_way_sorted_merge_top_defines.svh @@
// Assertion macros used by the merge block's checker.
`ifndef K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define K_WAY_SORTED_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kwm_pkg.sv @@
// Constants, item types and helper functions of the k-way merge block.
package kwm_pkg;

    localparam int LISTS       = 4;
    localparam int FIFO_DEPTH  = 16;
    localparam int MAX_RESULTS = 64;

    localparam int LIST_W = $clog2(LISTS);
    localparam int ACT_W  = $clog2(LISTS + 1);
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int ELEMS  = LISTS * FIFO_DEPTH;
    localparam int ADDR_W = $clog2(ELEMS);
    localparam int N_W    = $clog2(MAX_RESULTS + 1);
    localparam int CFG_W  = 3;

    typedef struct packed {
        logic [1:0]         list_id;
        logic signed [31:0] element_value;
        logic               has_element;
        logic               end_of_list;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [1:0]         source_list;
        logic               last_of_merge;
        logic               dropped;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // Clamp the programmed list count into 1..LISTS.
    function automatic logic [ACT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
        logic [ACT_W-1:0] r;
        if (cfg == '0)
            r = ACT_W'(1);
        else if (32'(cfg) > LISTS)
            r = ACT_W'(LISTS);
        else
            r = ACT_W'(cfg);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) + 1 >= FIFO_DEPTH)
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LIST_W-1:0] lst,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(32'(lst) * FIFO_DEPTH + 32'(p));
    endfunction

endpackage

@@ hw/rtl/k_way_sorted_merge_top.sv @@
// Top level of the k-way sorted merge: list FIFOs in one store, head scan, output register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid / in_ready   | in_data  (list, element, end mark)
//  out     | output    | out_valid / out_ready | out_data (value, source, flags)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (active list count)
//
// An input item that causes no result is accepted, then passes the completion
// check; a dropped item skips the check, its result waits in the output register.
// Each merged result takes a check, a head scan that reads one list head per cycle
// from the single read port of the element store, the registered read of the last
// head, the pick of the winner, and the pop of the winner into the output register.
// Reset clears pointers, fill counts, finished flags and the output valid flag;
// the element store needs no clearing since an entry is read only once written.
// A stalled output holds the sequencer before the pop; new items are taken
// only while idle and while the output register can take a drop result.
module k_way_sorted_merge_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kwm_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kwm_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]      cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam int LIST_W = kwm_pkg::LIST_W;
    localparam int ACT_W  = kwm_pkg::ACT_W;
    localparam int PTR_W  = kwm_pkg::PTR_W;
    localparam int CNT_W  = kwm_pkg::CNT_W;
    localparam int N_W    = kwm_pkg::N_W;

    // Sequencer and list bookkeeping
    logic [1:0]                 state_reg, state_next;
    logic [kwm_pkg::CFG_W-1:0]  act_cfg_reg, act_cfg_next;
    logic [PTR_W-1:0]           rp_reg [kwm_pkg::LISTS];
    logic [PTR_W-1:0]           rp_next [kwm_pkg::LISTS];
    logic [PTR_W-1:0]           wp_reg [kwm_pkg::LISTS];
    logic [PTR_W-1:0]           wp_next [kwm_pkg::LISTS];
    logic [CNT_W-1:0]           fill_reg [kwm_pkg::LISTS];
    logic [CNT_W-1:0]           fill_next [kwm_pkg::LISTS];
    logic [kwm_pkg::LISTS-1:0]  fin_reg, fin_next;
    logic [N_W-1:0]             n_reg, n_next;

    // Head scan
    logic [ACT_W-1:0]           scan_reg, scan_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [LIST_W-1:0]          pend_list_reg, pend_list_next;
    logic                       found_reg, found_next;
    logic signed [31:0]         best_val_reg, best_val_next;
    logic [LIST_W-1:0]          best_list_reg, best_list_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    kwm_pkg::out_item_t         out_data_reg, out_data_next;

    kwm_pkg::mem_req_t          mem_req;
    logic [31:0]                rd_data;

    logic [ACT_W-1:0]           act;
    logic                       out_free;
    logic                       id_active;
    logic [LIST_W-1:0]          in_idx;
    logic [LIST_W-1:0]          scan_idx;
    logic                       complete_now;
    logic                       lists_ready;
    logic                       complete_after;
    logic                       zero_after;

    kwm_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign act       = kwm_pkg::active_count(act_cfg_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_idx    = LIST_W'(in_data.list_id);
    assign id_active = 32'(in_data.list_id) < 32'(act);
    assign scan_idx  = scan_reg[LIST_W-1:0];

    // Merge is complete when every active list is finished and empty;
    // emission may proceed only while no unfinished active list runs dry.
    always_comb
    begin
        complete_now   = 1'b1;
        lists_ready    = 1'b1;
        complete_after = 1'b1;
        zero_after     = 1'b0;
        for (int l = 0; l < kwm_pkg::LISTS; l++)
        begin
            if (l < 32'(act))
            begin
                if (!(fin_reg[l] && fill_reg[l] == '0))
                    complete_now = 1'b0;
                if (!fin_reg[l] && fill_reg[l] == '0)
                    lists_ready = 1'b0;
                if (LIST_W'(l) == best_list_reg)
                    zero_after = (fill_reg[l] == CNT_W'(1));
                else
                    zero_after = (fill_reg[l] == '0);
                if (!(fin_reg[l] && zero_after))
                    complete_after = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        act_cfg_next    = act_cfg_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        fin_next        = fin_reg;
        n_next          = n_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_list_next  = pend_list_reg;
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_list_next  = best_list_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_req         = '0;

        // Retire the waiting result when taken.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_valid)
            act_cfg_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    n_next     = '0;
                    state_next = S_CHECK;
                    if (id_active && !fin_reg[in_idx])
                    begin
                        if (in_data.has_element &&
                            fill_reg[in_idx] == CNT_W'(kwm_pkg::FIFO_DEPTH))
                        begin
                            // FIFO full: drop the element, ignore its end mark.
                            out_valid_next              = 1'b1;
                            out_data_next.merged_value  = in_data.element_value;
                            out_data_next.source_list   = in_data.list_id;
                            out_data_next.last_of_merge = 1'b0;
                            out_data_next.dropped       = 1'b1;
                            state_next                  = S_IDLE;
                        end
                        else
                        begin
                            if (in_data.has_element)
                            begin
                                mem_req.we        = 1'b1;
                                mem_req.waddr     = kwm_pkg::mem_addr(in_idx, wp_reg[in_idx]);
                                mem_req.wdata     = in_data.element_value;
                                wp_next[in_idx]   = kwm_pkg::next_ptr(wp_reg[in_idx]);
                                fill_next[in_idx] = fill_reg[in_idx] + CNT_W'(1);
                            end
                            if (in_data.end_of_list)
                                fin_next[in_idx] = 1'b1;
                        end
                    end
                end
            end

            S_CHECK:
            begin
                scan_next  = '0;
                found_next = 1'b0;
                if (complete_now)
                begin
                    fin_next   = '0;
                    state_next = S_IDLE;
                end
                else if (n_reg >= N_W'(kwm_pkg::MAX_RESULTS) || !lists_ready)
                    state_next = S_IDLE;
                else
                    state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Compare the head read in the previous cycle; ties keep the lower list.
                if (pend_valid_reg)
                begin
                    if (!found_reg || $signed(rd_data) < best_val_reg)
                    begin
                        found_next     = 1'b1;
                        best_val_next  = $signed(rd_data);
                        best_list_next = pend_list_reg;
                    end
                end
                if (scan_reg < act)
                begin
                    pend_valid_next = (fill_reg[scan_idx] != '0);
                    pend_list_next  = scan_idx;
                    mem_req.re      = (fill_reg[scan_idx] != '0);
                    mem_req.raddr   = kwm_pkg::mem_addr(scan_idx, rp_reg[scan_idx]);
                    scan_next       = scan_reg + ACT_W'(1);
                end
                else if (!pend_valid_reg)
                    state_next = found_reg ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rp_next[best_list_reg]      = kwm_pkg::next_ptr(rp_reg[best_list_reg]);
                    fill_next[best_list_reg]    = fill_reg[best_list_reg] - CNT_W'(1);
                    out_valid_next              = 1'b1;
                    out_data_next.merged_value  = best_val_reg;
                    out_data_next.source_list   = 2'(best_list_reg);
                    out_data_next.last_of_merge = complete_after;
                    out_data_next.dropped       = 1'b0;
                    n_next                      = n_reg + N_W'(1);
                    state_next                  = S_CHECK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_cfg_reg    <= kwm_pkg::CFG_W'(4);
            fin_reg        <= '0;
            n_reg          <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int l = 0; l < kwm_pkg::LISTS; l++)
            begin
                rp_reg[l]   <= '0;
                wp_reg[l]   <= '0;
                fill_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            act_cfg_reg    <= act_cfg_next;
            fin_reg        <= fin_next;
            n_reg          <= n_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        pend_list_reg <= pend_list_next;
        best_val_reg  <= best_val_next;
        best_list_reg <= best_list_next;
        out_data_reg  <= out_data_next;
    end

endmodule

@@ hw/rtl/kwm_store.sv @@
// Element store: one write port, one read port, registered read data.
module kwm_store (
    input  logic              clk,
    input  kwm_pkg::mem_req_t req,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [kwm_pkg::ELEMS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

@@ hw/rtl/kwm_checker.sv @@
// Port-level checker of the merge block and its bind to the top level.
`include "k_way_sorted_merge_top_defines.svh"

module kwm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input kwm_pkg::out_item_t out_data
);

    `KWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
    `KWM_ASSERT_NOW(a_drop_not_last, out_valid && out_data.dropped, !out_data.last_of_merge, "drop result flagged last")
    `KWM_ASSERT_NOW(a_in_needs_room, in_ready, !out_valid || out_ready, "input taken with output blocked")
    `KWM_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready && !out_valid, !(in_ready && out_valid && !out_data.dropped), "merge result and new item overlap")

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (.*);

@@ tb/kwm_merge_check_pkg.sv @@
// Merge predictor and result checker for the k-way merge testbench.
package kwm_merge_check_pkg;

    import kwm_pkg::*;

    class merge_checker;

        // Own copy of the list FIFOs, pointers, end flags and list count.
        logic signed [31:0] elem_mem [LISTS*FIFO_DEPTH];
        int                 head [LISTS];
        int                 tail [LISTS];
        int                 used [LISTS];
        bit                 closed [LISTS];
        logic [CFG_W-1:0]   list_count_reg;

        out_item_t          expected_q [$];

        int errors;
        int items_seen;
        int results_seen;
        int drops_seen;
        int merges_done;

        function new();
            for (int l = 0; l < LISTS; l++)
            begin
                head[l]   = 0;
                tail[l]   = 0;
                used[l]   = 0;
                closed[l] = 1'b0;
            end
            list_count_reg = CFG_W'(4);
            errors         = 0;
            items_seen     = 0;
            results_seen   = 0;
            drops_seen     = 0;
            merges_done    = 0;
        endfunction

        function void set_list_count(logic [CFG_W-1:0] v);
            list_count_reg = v;
        endfunction

        // Zero counts as one list, anything above LISTS as LISTS.
        function int lists_in_use();
            if (list_count_reg == '0)
                return 1;
            if (int'(list_count_reg) > LISTS)
                return LISTS;
            return int'(list_count_reg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit all_drained(int n_lists);
            for (int l = 0; l < n_lists; l++)
                if (!closed[l] || used[l] != 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void push_result(logic signed [31:0] v, int src, bit last, bit drop);
            out_item_t r;
            r.merged_value  = v;
            r.source_list   = 2'(src);
            r.last_of_merge = last;
            r.dropped       = drop;
            expected_q.push_back(r);
        endfunction

        // Take one accepted item and queue every result it causes.
        function void note_item(in_item_t it);
            int                 n_lists;
            int                 id;
            int                 emitted;
            int                 best;
            bit                 found;
            bit                 all_have;
            logic signed [31:0] best_v;
            logic signed [31:0] v;

            n_lists = lists_in_use();
            id      = int'(it.list_id);
            emitted = 0;
            items_seen++;

            if (id < n_lists && !closed[id])
            begin
                if (it.has_element)
                begin
                    if (used[id] >= FIFO_DEPTH)
                    begin
                        push_result(it.element_value, id, 1'b0, 1'b1);
                        return;
                    end
                    elem_mem[id*FIFO_DEPTH + tail[id]] = it.element_value;
                    tail[id] = (tail[id] + 1) % FIFO_DEPTH;
                    used[id]++;
                end
                if (it.end_of_list)
                    closed[id] = 1'b1;
            end

            while (1)
            begin
                if (all_drained(n_lists))
                begin
                    for (int l = 0; l < LISTS; l++)
                        closed[l] = 1'b0;
                    break;
                end
                if (emitted >= MAX_RESULTS)
                    break;
                all_have = 1'b1;
                for (int l = 0; l < n_lists; l++)
                    if (!closed[l] && used[l] == 0)
                        all_have = 1'b0;
                if (!all_have)
                    break;

                found  = 1'b0;
                best   = 0;
                best_v = '0;
                for (int l = 0; l < n_lists; l++)
                begin
                    if (used[l] != 0)
                    begin
                        v = elem_mem[l*FIFO_DEPTH + head[l]];
                        if (!found || v < best_v)
                        begin
                            found  = 1'b1;
                            best   = l;
                            best_v = v;
                        end
                    end
                end
                if (!found)
                    break;

                head[best] = (head[best] + 1) % FIFO_DEPTH;
                used[best]--;
                push_result(best_v, best, all_drained(n_lists), 1'b0);
                emitted++;
            end
        endfunction

        // Compare one accepted result with the oldest expected one.
        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: value %0d list %0d last %0b dropped %0b",
                       got.merged_value, got.source_list, got.last_of_merge, got.dropped);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (want.dropped)
                drops_seen++;
            if (want.last_of_merge)
                merges_done++;
            if (got.merged_value !== want.merged_value)
            begin
                $error("merged_value: expected %0d, got %0d", want.merged_value, got.merged_value);
                errors++;
            end
            if (got.source_list !== want.source_list)
            begin
                $error("source_list: expected %0d, got %0d", want.source_list, got.source_list);
                errors++;
            end
            if (got.last_of_merge !== want.last_of_merge)
            begin
                $error("last_of_merge: expected %0b, got %0b",
                       want.last_of_merge, got.last_of_merge);
                errors++;
            end
            if (got.dropped !== want.dropped)
            begin
                $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/k_way_sorted_merge_top_test.sv @@
// Self-checking testbench of the k-way sorted merge top level.
module k_way_sorted_merge_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;
    import kwm_merge_check_pkg::*;

    // Worst settle time after the last result: two result scans plus margin covers it.
    localparam int SETTLE_CYCLES = 2 * (LISTS + 4) + 4;
    localparam int MAX_GAP       = 40;
    localparam int PHASE_ITEMS   = 17;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    merge_checker       sb;

    // Percent of cycles in which each side holds off.
    int send_idle_pct;
    int recv_idle_pct;

    k_way_sorted_merge_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Receiver: draw ready at each falling edge, take results at the rising edge.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Number of idle cycles before the next item, capped.
    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    function automatic in_item_t mk_item(int id, logic signed [31:0] v, bit has, bit eol);
        in_item_t it;
        it.list_id       = 2'(id);
        it.element_value = v;
        it.has_element   = has;
        it.end_of_list   = eol;
        return it;
    endfunction

    // Present one item, hold it until accepted, then hand it to the predictor.
    // Valid stays high into the next item when there is no gap.
    task automatic send_item(in_item_t it);
        int gap;
        gap = idle_gap(send_idle_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program the list count; only done with the block idle.
    task automatic write_list_count(logic [CFG_W-1:0] v);
        wait_drain();
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_list_count(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t noise_item();
        in_item_t it;
        it.list_id       = 2'($urandom_range(3));
        it.element_value = $urandom();
        it.has_element   = $urandom_range(1);
        it.end_of_list   = $urandom_range(1);
        return it;
    endfunction

    // One merge: an ascending run per active list, interleaved at random,
    // with some noise, some lists left open and now and then one list
    // flooded first so its FIFO fills up and may overflow.
    task automatic send_merge();
        in_item_t run_q [LISTS][$];
        in_item_t it;
        int       n_lists;
        int       flood;
        int       len;
        int       pick;
        int       left;
        int       r;
        longint   v;

        n_lists = sb.lists_in_use();
        flood   = -1;
        if (n_lists > 1 && $urandom_range(9) < 2)
            flood = $urandom_range(n_lists - 1);

        for (int l = 0; l < n_lists; l++)
        begin
            len = (l == flood) ? $urandom_range(16, 19) : $urandom_range(0, 5);
            case ($urandom_range(3))
                0:       begin r = $urandom(); v = r; end
                1:       v = longint'(VAL_MIN) + $urandom_range(8);
                2:       v = longint'(VAL_MAX) - $urandom_range(8);
                default: v = longint'($urandom_range(20)) - 10;
            endcase
            for (int k = 0; k < len; k++)
            begin
                run_q[l].push_back(mk_item(l, v[31:0], 1'b1, 1'b0));
                v = v + $urandom_range(3);
                if (v > longint'(VAL_MAX))
                    v = longint'(VAL_MAX);
            end
            // Close the list on its last element, with a bare mark, or not at all.
            if ($urandom_range(99) >= 12)
            begin
                if (len > 0 && $urandom_range(1))
                    run_q[l][run_q[l].size() - 1].end_of_list = 1'b1;
                else
                    run_q[l].push_back(mk_item(l, $urandom(), 1'b0, 1'b1));
            end
        end

        if (flood >= 0)
            while (run_q[flood].size() != 0)
            begin
                it = run_q[flood].pop_front();
                send_item(it);
            end

        left = 0;
        for (int l = 0; l < n_lists; l++)
            left += run_q[l].size();
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
                send_item(noise_item());
            do
                pick = $urandom_range(n_lists - 1);
            while (run_q[pick].size() == 0);
            it = run_q[pick].pop_front();
            send_item(it);
            left--;
        end
    endtask

    // Random phase at one list count and one idling mix; pause the sender
    // once mid-phase until the output has caught up.
    task automatic run_phase(logic [CFG_W-1:0] count, int s_pct, int r_pct);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_list_count(count);
        start = sb.items_seen;
        send_merge();
        wait_drain();
        while (sb.items_seen - start < PHASE_ITEMS)
            send_merge();
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 14;
        recv_idle_pct = 63;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Count above LISTS acts as LISTS.
        write_list_count(CFG_W'(7));

        // Field extremes, a three-way tie at 5, an out-of-order element,
        // a bare end mark, an item for a closed list and the final result.
        send_item(mk_item(0, VAL_MIN, 1'b1, 1'b0));
        send_item(mk_item(1, VAL_MAX, 1'b1, 1'b0));
        send_item(mk_item(2, 32'sd5, 1'b1, 1'b0));
        send_item(mk_item(3, 32'sd5, 1'b1, 1'b0));
        send_item(mk_item(0, 32'sd5, 1'b1, 1'b1));
        send_item(mk_item(2, 32'sd0, 1'b0, 1'b1));
        send_item(mk_item(3, -32'sd1, 1'b1, 1'b1));
        send_item(mk_item(3, 32'sd9, 1'b1, 1'b0));
        send_item(mk_item(1, VAL_MAX, 1'b1, 1'b1));

        // One list: an item for an inactive list, a pass-through element,
        // then a bare end mark that closes an empty merge.
        write_list_count(CFG_W'(1));
        send_item(mk_item(3, 32'sd3, 1'b1, 1'b0));
        send_item(mk_item(0, 32'sd10, 1'b1, 1'b0));
        send_item(mk_item(0, 32'sd0, 1'b0, 1'b1));

        // Two lists: fill list 1 while list 0 stays empty, overflow it with
        // an end mark that must be ignored, then release the burst.
        write_list_count(CFG_W'(2));
        for (int k = 0; k < FIFO_DEPTH; k++)
            send_item(mk_item(1, 32'(k * 100), 1'b1, 1'b0));
        send_item(mk_item(1, 32'sd9999, 1'b1, 1'b1));
        send_item(mk_item(0, 32'sd50, 1'b1, 1'b1));
        send_item(mk_item(1, 32'sd0, 1'b0, 1'b1));

        // Random part: sender light / receiver heavy, then swapped, then free.
        run_phase(CFG_W'(4), 14, 63);
        run_phase(CFG_W'(1), 14, 63);
        run_phase(CFG_W'(0), 14, 63);
        run_phase(CFG_W'(7), 63, 14);
        run_phase(CFG_W'(2), 63, 14);
        run_phase(CFG_W'(3), 63, 14);
        run_phase(CFG_W'(3), 0, 0);
        run_phase(CFG_W'(2), 0, 0);
        run_phase(CFG_W'(4), 0, 0);

        wait_drain();

        $display("Sent %0d input items; checked %0d results, %0d of them drops, %0d merge ends.",
                 sb.items_seen, sb.results_seen, sb.drops_seen, sb.merges_done);
        $display("List counts 0 to 4 and 7 were programmed, with stalls on either side and none.");
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
